### hdl/csp_pkg.sv
package csp_pkg;
  localparam int unsigned MaxConn = 16;
  localparam int unsigned IdxW = $clog2(MaxConn);
  localparam int unsigned CntW = $clog2(MaxConn + 1);

  localparam logic [16:0] IdleDefault = 17'd300;
  localparam logic [4:0]  HostDefault = 5'd4;

  localparam logic [7:0] RegMaxIdle = 8'd0;
  localparam logic [7:0] RegMaxHost = 8'd1;

  typedef enum logic [1:0] {
    OpAcquire = 2'd0,
    OpRelease = 2'd1,
    OpEvict   = 2'd2,
    OpCloseAll = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StHostFull = 2'd1,
    StTblFull  = 2'd2,
    StBadSlot  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SAcqScan,
    SAcqEnd,
    SEvict
  } state_e;
endpackage

### hdl/connection_slot_pool.sv
// Connection slot pool.
// Command channel: an operation transfer happens at a rising edge with start_i
// high and busy_o low; operation_i, host_key_i, port_i, slot_i and now_i are
// sampled then. Exactly one result follows per command, shown for one cycle
// with valid_o high; the receiver cannot stall, so the result is simply
// presented and dropped. busy_o is high from an acquire or evict transfer
// to its result and stays low for release and close-all. Release and
// close-all load the result register at the transfer; acquire scans the
// table in SAcqScan up to the step that sees the end of the table, then
// passes SAcqEnd, which loads the result register; evict compacts the
// table in SEvict, and its step that sees the end loads the result
// register. The slot scan reads one table entry per cycle. A new command
// can be taken in the cycle the result is shown.
// Configuration: cfg_we_i writes register cfg_idx_i (0 idle age limit,
// 1 per-host slot limit) from cfg_data_i; other indexes are ignored.
// Write only idle.
// Reset clears the slot count and loads the register defaults; the table
// contents are left as they are and are only used below the slot count.
// Evict keeps the order of surviving slots and packs them to the bottom.
module connection_slot_pool import csp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] host_key_i,
  input  logic [15:0] port_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] now_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_out_o,
  output logic        reused_o,
  output logic [31:0] use_total_o,
  output logic [4:0]  evicted_o
);

  // slot table (flops, one read index per cycle)
  logic [31:0] host_q [MaxConn];
  logic [15:0] port_q [MaxConn];
  logic        inuse_q [MaxConn];
  logic [31:0] uses_q [MaxConn];
  logic [31:0] last_q [MaxConn];

  state_e      state_q, state_d;
  logic [CntW-1:0] live_q;
  logic [CntW-1:0] idx_q, idx_d;    // scan / read pointer
  logic [CntW-1:0] wr_q, wr_d;      // evict write pointer
  logic [CntW-1:0] same_q, same_d;  // slots held by the host key
  logic        found_q, found_d;
  logic [IdxW-1:0] fidx_q, fidx_d;
  logic [31:0] fuses_q, fuses_d;

  logic [31:0] cmd_key_q, cmd_now_q;
  logic [15:0] cmd_port_q;
  logic [16:0] max_idle_q;
  logic [4:0]  max_host_q;

  logic        valid_q;
  logic [1:0]  status_q;
  logic [3:0]  slot_q;
  logic        reused_q;
  logic [31:0] total_q;
  logic [4:0]  evicted_q;

  logic        accept;
  logic        scan_end;
  logic [IdxW-1:0] ridx;
  logic        key_hit, idle_hit, keep;
  logic [31:0] age;
  logic [16:0] age_lim;
  logic [4:0]  host_lim;

  assign accept   = start_i && (state_q == SIdle);
  assign scan_end = (idx_q == live_q);
  assign ridx     = idx_q[IdxW-1:0];
  assign key_hit  = (host_q[ridx] == cmd_key_q);
  assign idle_hit = !inuse_q[ridx] && key_hit && (port_q[ridx] == cmd_port_q);
  assign age_lim  = (max_idle_q == '0) ? IdleDefault : max_idle_q;
  assign host_lim = (max_host_q == '0) ? HostDefault : max_host_q;
  assign age      = cmd_now_q - last_q[ridx];
  assign keep     = inuse_q[ridx] || (age <= {15'd0, age_lim});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (operation_i == OpAcquire) state_d = SAcqScan;
          else if (operation_i == OpEvict) state_d = SEvict;
        end
      end
      SAcqScan: if (scan_end) state_d = SAcqEnd;
      SAcqEnd:  state_d = SIdle;
      SEvict:   if (scan_end) state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  // scan datapath
  always_comb begin
    idx_d   = idx_q;
    wr_d    = wr_q;
    same_d  = same_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    fuses_d = fuses_q;
    unique case (state_q)
      SIdle: begin
        idx_d   = '0;
        wr_d    = '0;
        same_d  = '0;
        found_d = 1'b0;
      end
      SAcqScan: begin
        if (!scan_end) begin
          idx_d = idx_q + 1'b1;
          if (key_hit) same_d = same_q + 1'b1;
          if (idle_hit && !found_q) begin
            found_d = 1'b1;
            fidx_d  = ridx;
            fuses_d = uses_q[ridx] + 32'd1;
          end
        end
      end
      SEvict: begin
        if (!scan_end) begin
          idx_d = idx_q + 1'b1;
          if (keep) wr_d = wr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      live_q     <= '0;
      valid_q    <= 1'b0;
      max_idle_q <= IdleDefault;
      max_host_q <= HostDefault;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMaxIdle) max_idle_q <= cfg_data_i;
        else if (cfg_idx_i == RegMaxHost) max_host_q <= cfg_data_i[4:0];
      end
      if (accept) begin
        if (operation_i == OpRelease) begin
          valid_q <= 1'b1;
        end else if (operation_i == OpCloseAll) begin
          valid_q <= 1'b1;
          live_q  <= '0;
        end
      end
      if (state_q == SAcqEnd) begin
        valid_q <= 1'b1;
        if (!found_q && same_q < host_lim && live_q < CntW'(MaxConn))
          live_q <= live_q + 1'b1;
      end
      if (state_q == SEvict && scan_end) begin
        valid_q <= 1'b1;
        live_q  <= wr_q;
      end
    end
  end

  // payload and table
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    wr_q    <= wr_d;
    same_q  <= same_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    fuses_q <= fuses_d;
    if (accept) begin
      cmd_key_q  <= host_key_i;
      cmd_port_q <= port_i;
      cmd_now_q  <= now_i;
      status_q   <= StOk;
      slot_q     <= '0;
      reused_q   <= 1'b0;
      total_q    <= '0;
      evicted_q  <= '0;
      if (operation_i == OpRelease) begin
        if (CntW'(slot_i) >= live_q) begin
          status_q <= StBadSlot;
        end else begin
          inuse_q[slot_i[IdxW-1:0]] <= 1'b0;
          last_q[slot_i[IdxW-1:0]]  <= now_i;
        end
      end
    end
    if (state_q == SAcqEnd) begin
      priority if (found_q) begin
        inuse_q[fidx_q] <= 1'b1;
        uses_q[fidx_q]  <= fuses_q;
        slot_q   <= 4'(fidx_q);
        reused_q <= 1'b1;
        total_q  <= fuses_q;
      end else if (same_q >= host_lim) begin
        status_q <= StHostFull;
      end else if (live_q >= CntW'(MaxConn)) begin
        status_q <= StTblFull;
      end else begin
        host_q[live_q[IdxW-1:0]]  <= cmd_key_q;
        port_q[live_q[IdxW-1:0]]  <= cmd_port_q;
        inuse_q[live_q[IdxW-1:0]] <= 1'b1;
        uses_q[live_q[IdxW-1:0]]  <= 32'd1;
        last_q[live_q[IdxW-1:0]]  <= '0;
        slot_q  <= 4'(live_q[IdxW-1:0]);
        total_q <= 32'd1;
      end
    end
    if (state_q == SEvict) begin
      if (!scan_end && keep) begin
        host_q[wr_q[IdxW-1:0]]  <= host_q[ridx];
        port_q[wr_q[IdxW-1:0]]  <= port_q[ridx];
        inuse_q[wr_q[IdxW-1:0]] <= inuse_q[ridx];
        uses_q[wr_q[IdxW-1:0]]  <= uses_q[ridx];
        last_q[wr_q[IdxW-1:0]]  <= last_q[ridx];
      end
      if (scan_end) evicted_q <= 5'(live_q - wr_q);
    end
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_q;
  assign reused_o    = reused_q;
  assign use_total_o = total_q;
  assign evicted_o   = evicted_q;

`ifndef SYNTHESIS
  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(MaxConn)) else $error("slot count beyond table");
  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEvict) |-> (wr_q <= idx_q)) else $error("evict write overtook read");
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAcqEnd) |=> valid_o) else $error("acquire ended without result");
`endif
endmodule

### sim/tb_connection_slot_pool.sv
`timescale 1ns / 100ps

module tb_connection_slot_pool;
  import csp_pkg::*;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] host_key_i = '0;
  logic [15:0] port_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] now_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [3:0]  slot_out_o;
  logic        reused_o;
  logic [31:0] use_total_o;
  logic [4:0]  evicted_o;

  connection_slot_pool uut (.*);

  // 4 ns period
  always #2 clk_i = ~clk_i;

  // One expected response per command transfer
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic        reused;
    logic [31:0] uses;
    logic [4:0]  evicted;
  } pool_resp_t;

  pool_resp_t pending_resp[$];
  int unsigned mismatches = 0;
  bit          no_gaps = 1'b0;   // back-to-back stretches when set
  logic [31:0] clock_sec = '0;   // running wall time fed to now_i

  // Shadow copy of the slot table and registers
  logic [31:0] pool_host [MaxConn];
  logic [15:0] pool_port [MaxConn];
  logic        pool_busy [MaxConn];
  logic [31:0] pool_uses [MaxConn];
  logic [31:0] pool_stamp[MaxConn];
  int unsigned pool_live = 0;
  logic [16:0] idle_lim = IdleDefault;
  logic [4:0]  host_lim = HostDefault;

  // Work out the response for one command and update the shadow table
  function automatic pool_resp_t pool_apply(op_e op, logic [31:0] key, logic [15:0] prt,
                                            logic [3:0] sl, logic [31:0] tnow);
    pool_resp_t r;
    bit          hit;
    int unsigned same;
    int unsigned lim;
    logic [31:0] age_lim;
    r = '0;
    r.status = StOk;
    hit = 1'b0;
    same = 0;
    case (op)
      OpAcquire: begin
        for (int i = 0; i < pool_live; i++) begin
          if (!hit && !pool_busy[i] && pool_port[i] == prt && pool_host[i] == key) begin
            hit = 1'b1;
            pool_busy[i] = 1'b1;
            pool_uses[i] = pool_uses[i] + 32'd1;
            r.slot = i[3:0];
            r.reused = 1'b1;
            r.uses = pool_uses[i];
          end
        end
        if (!hit) begin
          lim = (host_lim == 0) ? 4 : host_lim;
          for (int i = 0; i < pool_live; i++)
            if (pool_host[i] == key) same++;
          if (same >= lim) begin
            r.status = StHostFull;
          end else if (pool_live >= MaxConn) begin
            r.status = StTblFull;
          end else begin
            pool_host[pool_live]  = key;
            pool_port[pool_live]  = prt;
            pool_busy[pool_live]  = 1'b1;
            pool_uses[pool_live]  = 32'd1;
            pool_stamp[pool_live] = '0;
            r.slot = pool_live[3:0];
            r.uses = 32'd1;
            pool_live++;
          end
        end
      end
      OpRelease: begin
        if (sl >= pool_live) begin
          r.status = StBadSlot;
        end else begin
          pool_busy[sl]  = 1'b0;
          pool_stamp[sl] = tnow;
        end
      end
      OpEvict: begin
        age_lim = (idle_lim == 0) ? 32'd300 : {15'd0, idle_lim};
        // top down; each removal packs the later slots down by one
        for (int k = int'(pool_live) - 1; k >= 0; k--) begin
          if (!pool_busy[k] && (tnow - pool_stamp[k]) > age_lim) begin
            for (int j = k; j + 1 < pool_live; j++) begin
              pool_host[j]  = pool_host[j+1];
              pool_port[j]  = pool_port[j+1];
              pool_busy[j]  = pool_busy[j+1];
              pool_uses[j]  = pool_uses[j+1];
              pool_stamp[j] = pool_stamp[j+1];
            end
            pool_live--;
            r.evicted++;
          end
        end
      end
      default: pool_live = 0;
    endcase
    return r;
  endfunction

  // Random pause after a transfer: mostly none or short, now and then long
  task automatic idle_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    n = no_gaps ? 0 : (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
    if (n > 0) begin
      start_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Issue one command; called at a falling edge, returns at a falling edge.
  // start_i is left high so a following command can go straight out.
  task automatic send_cmd(op_e op, logic [31:0] key, logic [15:0] prt,
                          logic [3:0] sl, logic [31:0] tnow);
    operation_i = op;
    host_key_i  = key;
    port_i      = prt;
    slot_i      = sl;
    now_i       = tnow;
    start_i     = 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_resp.push_back(pool_apply(op, key, prt, sl, tnow));
    @(negedge clk_i);
    idle_gap();
  endtask

  // Wait until every response is in, plus margin for the longest scan
  task automatic drain();
    start_i = 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(logic [7:0] idx, logic [16:0] val);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegMaxIdle) idle_lim = val;
    else if (idx == RegMaxHost) host_lim = val[4:0];
  endtask

  // Response checker: no back-pressure, so every valid cycle is a transfer
  always @(posedge clk_i) begin
    pool_resp_t want;
    if (rst_ni && valid_o) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
      end else begin
        want = pending_resp.pop_front();
        if (status_o !== want.status || slot_out_o !== want.slot ||
            reused_o !== want.reused || use_total_o !== want.uses ||
            evicted_o !== want.evicted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp st=%0d sl=%0d ru=%0d use=%0d ev=%0d, got st=%0d sl=%0d ru=%0d use=%0d ev=%0d",
                     $realtime, want.status, want.slot, want.reused, want.uses, want.evicted,
                     status_o, slot_out_o, reused_o, use_total_o, evicted_o);
        end
      end
    end
  end

  // Corner cases: field extremes, reuse, host limit, bad slot, wrapping age
  task automatic test_directed();
    send_cmd(OpCloseAll, '0, '0, '0, '0);
    send_cmd(OpAcquire, 32'h0, 16'h0, '0, '0);
    send_cmd(OpAcquire, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    send_cmd(OpRelease, '0, '0, 4'd0, 32'hFFFF_FFFF);
    send_cmd(OpAcquire, 32'h0, 16'h0, '0, '0);          // reuse of slot 0
    send_cmd(OpRelease, '0, '0, 4'd5, 32'd7);            // index past the table
    send_cmd(OpRelease, '0, '0, 4'hF, 32'd7);
    send_cmd(OpRelease, '0, '0, 4'd1, 32'hFFFF_FF00);
    send_cmd(OpRelease, '0, '0, 4'd1, 32'hFFFF_FFF0);    // release while idle
    send_cmd(OpEvict, '0, '0, '0, 32'd50);               // age wraps past zero
    for (int i = 0; i < 6; i++)                          // runs into the host limit
      send_cmd(OpAcquire, 32'hA5A5_5A5A, 16'(i), '0, '0);
    send_cmd(OpRelease, '0, '0, 4'd0, 32'd1000);
    send_cmd(OpEvict, '0, '0, '0, 32'd1300);             // age exactly the limit
    send_cmd(OpEvict, '0, '0, '0, 32'd1301);
    send_cmd(OpAcquire, 32'h1234_5678, 16'h8001, '0, '0);
    send_cmd(OpCloseAll, '0, '0, '0, '0);
    send_cmd(OpEvict, '0, '0, '0, 32'hFFFF_FFFF);        // empty table
    send_cmd(OpRelease, '0, '0, 4'd0, '0);
  endtask

  // Random traffic: a small key/port pool so slots get reused, filled and evicted
  task automatic test_random(int unsigned count);
    op_e         op;
    logic [31:0] key;
    logic [15:0] prt;
    logic [3:0]  sl;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 46) ? OpAcquire : (pick < 82) ? OpRelease :
           (pick < 97) ? OpEvict : OpCloseAll;
      key = ($urandom_range(0, 9) == 0) ? $urandom : 32'hC0DE_0000 + $urandom_range(0, 5);
      prt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(80, 82));
      sl  = ($urandom_range(0, 7) == 0 || pool_live == 0) ? 4'($urandom)
                                                          : 4'($urandom_range(0, pool_live - 1));
      pick = $urandom_range(0, 99);
      if (pick < 70) clock_sec = clock_sec + $urandom_range(0, 40);
      else if (pick < 95) clock_sec = clock_sec + $urandom_range(0, 400);
      else clock_sec = $urandom;
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_cmd(op, key, prt, sl, clock_sec);
    end
    no_gaps = 1'b0;
  endtask

  // Register extremes, zero values acting as defaults, and a dead index
  task automatic test_config();
    write_reg(RegMaxHost, 17'd1);
    write_reg(RegMaxIdle, 17'd1);
    test_random(250);
    write_reg(RegMaxHost, 17'd16);
    write_reg(RegMaxIdle, 17'd86400);
    test_random(250);
    write_reg(RegMaxHost, 17'd0);
    write_reg(RegMaxIdle, 17'd0);
    test_random(250);
    write_reg(RegMaxHost, 17'h1FFFF);
    write_reg(RegMaxIdle, 17'd131071);
    test_random(250);
    write_reg(8'd2, 17'h1AAAA);
    write_reg(8'hFF, 17'h15555);
    write_reg(RegMaxHost, 17'd2);
    write_reg(RegMaxIdle, 17'd60);
    test_random(250);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(280);
    test_config();
    drain();
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
